@@ sv/fbf_pkg.sv @@
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared types, constants and helpers for the framebuffer fill engine.
// ----------------------------------------------------------------------------
package fbf_pkg;

  // Frame geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int DIM_W       = 9;    // holds 0..256
  localparam int COORD_W     = 18;   // signed box coordinates before clipping
  localparam int MUL_W       = 16;   // signed operands of the shared multiplier
  localparam int SQ_W        = 31;   // squares stay below 2**30

  // Field widths
  localparam int COLOR_W     = 24;
  localparam int POS_W       = 16;
  localparam int EXT_W       = 15;
  localparam int IN_TDATA_W  = 88;   // 86 bits of fields, padded to bytes
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    ACT_DISC = 2'd0,
    ACT_RECT = 2'd1,
    ACT_BLIT = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BOX,
    ST_SETUP,
    ST_SQX,
    ST_BASE,
    ST_ROW,
    ST_PIX,
    ST_READ,
    ST_RDATA,
    ST_OUT
  } state_t;

  // Clip a signed coordinate into 0..hi
  function automatic logic [DIM_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
    logic signed [COORD_W-1:0] hi_s;
    hi_s = $signed({{(COORD_W-DIM_W){1'b0}}, hi});
    if (v < 0) begin
      clamp_coord = '0;
    end else if (v > hi_s) begin
      clamp_coord = hi;
    end else begin
      clamp_coord = v[DIM_W-1:0];
    end
  endfunction

endpackage

@@ sv/framebuffer_fill_engine.sv @@
// ----------------------------------------------------------------------------
// framebuffer_fill_engine
// Disc, rectangle, blit-pixel and read commands on a 24-bit RGB frame store,
// clipped to the configured frame, walked one pixel per cycle within each row.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  in_*      in    tuser: action; tdata: pos_x, pos_y, extent_a, extent_b,
//                  paint_color
//  out_*     out   tdata: read_color (zero for write commands)
//  cfg_*     in    write enable, register index, 9-bit data
//
//  After reset a clearing pass writes white to all 65536 pixels, one per
//  cycle; in_tready stays low until the pass is done.
//  Each command clips its box; the shared multiplier then forms r^2, the first
//  column's dx^2, the row base and each row's dy^2, and fills write the store
//  port pixel by pixel (a read fetches its pixel); an empty box skips the rest.
//  One command at a time: in_tready is low from accept until the result beat
//  is taken, and the result waits in a register while out_tready is low.
// ----------------------------------------------------------------------------
module framebuffer_fill_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  // input commands
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] pos_x, [31:16] pos_y, [46:32] extent_a, [61:47] extent_b,
  // [85:62] paint_color, [87:86] zero
  input  logic [fbf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] action
  input  logic [fbf_pkg::IN_TUSER_W-1:0]   in_tuser,
  // results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [23:0] read_color
  output logic [fbf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration
  input  logic                             cfg_we,
  input  logic [fbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fbf_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] act_w, act_h;

  // latched command
  action_t             act_r;
  logic [POS_W-1:0]    cx_r, cy_r;
  logic [EXT_W-1:0]    ea_r, eb_r;
  logic [COLOR_W-1:0]  color_r;

  // scan state
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [DIM_W-1:0]    x0_r, x1_r, y0_r, y1_r;
  logic [DIM_W-1:0]    x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  logic [DIM_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [16:0]  dx_r, dx_nxt;
  logic [SQ_W-1:0]     r2_r, r2_nxt, sqx0_r, sqx0_nxt, sq_r, sq_nxt, dy2_r, dy2_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [COLOR_W-1:0]  res_r, res_nxt;

  // box bounds before clipping
  logic signed [COORD_W-1:0] cx18, cy18, ea18, eb18;
  logic signed [COORD_W-1:0] lox, hix, loy, hiy;
  logic signed [COORD_W-1:0] dx0_full, dy_full;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  logic              box_empty, x_last, y_last, hit;
  logic [32:0]       sq_step;
  logic [ADDR_W-1:0] pix_addr;

  // store port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;

  fbf_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // active frame size, saturated to the store
  assign act_w = (width_r  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_r;
  assign act_h = (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unclipped box of the command
  assign cx18 = COORD_W'(signed'(cx_r));
  assign cy18 = COORD_W'(signed'(cy_r));
  assign ea18 = $signed({{(COORD_W-EXT_W){1'b0}}, ea_r});
  assign eb18 = $signed({{(COORD_W-EXT_W){1'b0}}, eb_r});

  always_comb begin
    case (act_r)
      ACT_DISC: begin
        lox = cx18 - ea18;
        hix = cx18 + ea18 + 18'sd1;
        loy = cy18 - ea18;
        hiy = cy18 + ea18 + 18'sd1;
      end
      ACT_RECT: begin
        lox = cx18;
        hix = cx18 + ea18;
        loy = cy18;
        hiy = cy18 + eb18;
      end
      ACT_BLIT: begin
        lox = cx18 + ea18;
        hix = cx18 + ea18 + 18'sd1;
        loy = cy18 + eb18;
        hiy = cy18 + eb18 + 18'sd1;
      end
      default: begin
        lox = cx18;
        hix = cx18 + 18'sd1;
        loy = cy18;
        hiy = cy18 + 18'sd1;
      end
    endcase
  end

  assign x0_nxt = clamp_coord(lox, act_w);
  assign x1_nxt = clamp_coord(hix, act_w);
  assign y0_nxt = clamp_coord(loy, act_h);
  assign y1_nxt = clamp_coord(hiy, act_h);

  // offsets from the centre; inside a nonempty disc box they fit 16 bits
  assign dx0_full = $signed({{(COORD_W-DIM_W){1'b0}}, x0_r}) - cx18;
  assign dy_full  = $signed({{(COORD_W-DIM_W){1'b0}}, y_r}) - cy18;

  assign box_empty = (x0_r >= x1_r) || (y0_r >= y1_r);
  assign x_last    = (x_r + DIM_W'(1)) == x1_r;
  assign y_last    = (y_r + DIM_W'(1)) == y1_r;
  assign pix_addr  = base_r + ADDR_W'(x_r);

  // disc test and next square: (dx+1)^2 = dx^2 + 2dx + 1
  assign hit     = ({2'b00, sq_r} + {2'b00, dy2_r}) <= {2'b00, r2_r};
  assign sq_step = 33'($signed({2'b00, sq_r}) + 33'($signed({dx_r, 1'b1})));

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_SETUP: begin
        mul_a = $signed({1'b0, ea_r});
        mul_b = $signed({1'b0, ea_r});
      end
      ST_SQX: begin
        mul_a = dx0_full[MUL_W-1:0];
        mul_b = dx0_full[MUL_W-1:0];
      end
      ST_BASE: begin
        mul_a = $signed({{(MUL_W-DIM_W){1'b0}}, y0_r});
        mul_b = $signed({{(MUL_W-DIM_W){1'b0}}, act_w});
      end
      default: begin
        mul_a = dy_full[MUL_W-1:0];
        mul_b = dy_full[MUL_W-1:0];
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_BOX;
      ST_BOX:   state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = box_empty ? ST_OUT : ST_SQX;
      ST_SQX:   state_nxt = ST_BASE;
      ST_BASE:  state_nxt = ST_ROW;
      ST_ROW:   state_nxt = (act_r == ACT_READ) ? ST_READ : ST_PIX;
      ST_PIX: begin
        if (x_last && y_last) begin
          state_nxt = ST_OUT;
        end else if (x_last) begin
          state_nxt = ST_ROW;
        end
      end
      ST_READ:  state_nxt = ST_RDATA;
      ST_RDATA: state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake and store port
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    out_tdata  = res_r;
    ram_we     = 1'b0;
    ram_addr   = pix_addr;
    ram_wdata  = color_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = COLOR_WHITE;
      end
      ST_PIX: ram_we = (act_r != ACT_DISC) || hit;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    clr_nxt  = clr_r + ADDR_W'(1);
    r2_nxt   = r2_r;
    sqx0_nxt = sqx0_r;
    sq_nxt   = sq_r;
    dy2_nxt  = dy2_r;
    dx_nxt   = dx_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    base_nxt = base_r;
    res_nxt  = res_r;
    case (state_r)
      ST_IDLE: res_nxt = COLOR_BLACK;
      ST_SETUP: r2_nxt = mul_p[SQ_W-1:0];
      ST_SQX: begin
        sqx0_nxt = mul_p[SQ_W-1:0];
        y_nxt    = y0_r;
      end
      ST_BASE: base_nxt = mul_p[ADDR_W-1:0];
      ST_ROW: begin
        dy2_nxt = mul_p[SQ_W-1:0];
        sq_nxt  = sqx0_r;
        x_nxt   = x0_r;
        dx_nxt  = dx0_full[16:0];
      end
      ST_PIX: begin
        x_nxt  = x_r + DIM_W'(1);
        dx_nxt = dx_r + 17'sd1;
        sq_nxt = sq_step[SQ_W-1:0];
        if (x_last) begin
          y_nxt    = y_r + DIM_W'(1);
          base_nxt = base_r + ADDR_W'(act_w);
        end
      end
      ST_RDATA: res_nxt = ram_rdata;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_nxt;
      end
    end
  end

  // command and scan registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r   <= action_t'(in_tuser);
      cx_r    <= in_tdata[15:0];
      cy_r    <= in_tdata[31:16];
      ea_r    <= in_tdata[46:32];
      eb_r    <= in_tdata[61:47];
      color_r <= in_tdata[85:62];
    end
    if (state_r == ST_BOX) begin
      x0_r <= x0_nxt;
      x1_r <= x1_nxt;
      y0_r <= y0_nxt;
      y1_r <= y1_nxt;
    end
    r2_r   <= r2_nxt;
    sqx0_r <= sqx0_nxt;
    sq_r   <= sq_nxt;
    dy2_r  <= dy2_nxt;
    dx_r   <= dx_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
  end

endmodule

@@ sv/fbf_ram.sv @@
// ----------------------------------------------------------------------------
// fbf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/fbf_checker.sv @@
// ----------------------------------------------------------------------------
// fbf_checker
// Port-level checks for the framebuffer fill engine, bound to the top level.
// ----------------------------------------------------------------------------
module fbf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fbf_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one command in flight: never ready while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("ready for a command while a result is pending");

  // an accepted command closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("input not closed after accept");

  // a taken result beat is not followed at once by another
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("second result beat without a new command");

endmodule

bind framebuffer_fill_engine fbf_checker u_fbf_checker (.*);

@@ sim/tb_framebuffer_fill_engine.sv @@
// ----------------------------------------------------------------------------
// tb_framebuffer_fill_engine
// Self-checking bench for the framebuffer fill engine. A driver streams disc,
// rectangle, blit and read commands through the in_* channel. A shadow frame
// store in the bench mirrors every write and works out the color that each
// command should return. A monitor checks each out_* beat against the oldest
// expected color. The frame size is changed between phases while the block
// is idle, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_framebuffer_fill_engine;
  import fbf_pkg::*;

  localparam int STALL_LIMIT = 200000;  // clear pass plus a full-frame fill, with margin
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RSVD3 = 2'd3;

  typedef struct packed {
    action_t                   act;
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic [EXT_W-1:0]          ea;
    logic [EXT_W-1:0]          eb;
    logic [COLOR_W-1:0]        color;
  } fill_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;  // pos_x, pos_y, extent_a, extent_b, paint_color
  logic [IN_TUSER_W-1:0] in_tuser = '0;  // action
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;     // read_color
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow frame and registers
  logic [COLOR_W-1:0] shadow_px [FRAME_DEPTH];
  int unsigned shadow_w;
  int unsigned shadow_h;

  fill_cmd_t cmd_q [$];
  fill_cmd_t cur_cmd;
  logic [COLOR_W-1:0] pend_colors [$];

  int tx_idle_pct = 12;
  int rx_idle_pct = 60;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  int phase_w [NUM_PHASES] = '{16, 1, 0, 40, 511, 37, 256, 64};
  int phase_h [NUM_PHASES] = '{12, 1, 40, 0, 300, 200, 1, 64};
  int phase_n [NUM_PHASES] = '{200, 60, 40, 40, 200, 200, 150, 240};

  framebuffer_fill_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- shadow

  function automatic longint eff_w();
    return longint'((shadow_w > MAX_WIDTH) ? MAX_WIDTH : shadow_w);
  endfunction

  function automatic longint eff_h();
    return longint'((shadow_h > MAX_HEIGHT) ? MAX_HEIGHT : shadow_h);
  endfunction

  function automatic bit on_frame(longint x, longint y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // disc: every pixel with dx*dx + dy*dy <= r*r, clipped to the frame
  function automatic void draw_disc(longint cx, longint cy, longint r, logic [COLOR_W-1:0] col);
    longint w, h, x0, x1, y0, y1, r2;
    w = eff_w();
    h = eff_h();
    r2 = r * r;
    if (w == 0 || h == 0) return;
    x0 = clip(cx - r, 0, w);
    x1 = clip(cx + r + 1, 0, w);
    y0 = clip(cy - r, 0, h);
    y1 = clip(cy + r + 1, 0, h);
    for (longint y = y0; y < y1; y++)
      for (longint x = x0; x < x1; x++)
        if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r2)
          shadow_px[y * w + x] = col;
  endfunction

  function automatic void draw_box(longint px, longint py, longint bw, longint bh,
                                   logic [COLOR_W-1:0] col);
    longint w, h, x0, x1, y0, y1;
    w = eff_w();
    h = eff_h();
    if (w == 0 || h == 0) return;
    x0 = clip(px, 0, w);
    x1 = clip(px + bw, 0, w);
    y0 = clip(py, 0, h);
    y1 = clip(py + bh, 0, h);
    for (longint y = y0; y < y1; y++)
      for (longint x = x0; x < x1; x++)
        shadow_px[y * w + x] = col;
  endfunction

  // apply one command to the shadow frame, return the expected read_color
  function automatic logic [COLOR_W-1:0] run_cmd(fill_cmd_t c);
    longint px, py, ea, eb;
    logic [COLOR_W-1:0] res;
    px = longint'(c.px);
    py = longint'(c.py);
    ea = longint'(c.ea);
    eb = longint'(c.eb);
    res = COLOR_BLACK;
    case (c.act)
      ACT_DISC: draw_disc(px, py, ea, c.color);
      ACT_RECT: draw_box(px, py, ea, eb, c.color);
      ACT_BLIT: begin
        if (on_frame(px + ea, py + eb))
          shadow_px[(py + eb) * eff_w() + px + ea] = c.color;
      end
      default: begin
        if (on_frame(px, py))
          res = shadow_px[py * eff_w() + px];
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drv
    fill_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      foreach (shadow_px[i]) shadow_px[i] = COLOR_WHITE;
      shadow_w = MAX_WIDTH;
      shadow_h = MAX_HEIGHT;
    end else begin
      // register writes land on this edge
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_WIDTH) shadow_w = 32'(cfg_data);
        else if (cfg_index == CFG_IDX_HEIGHT) shadow_h = 32'(cfg_data);
      end
      if (in_tvalid && in_tready)
        pend_colors.push_back(run_cmd(cur_cmd));
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = cmd_q.pop_front();
          cur_cmd = nxt;
          in_tdata <= {2'b00, nxt.color, nxt.eb, nxt.ea, nxt.py, nxt.px};
          in_tuser <= nxt.act;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : mon
    logic [COLOR_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pend_colors.size() == 0) begin
          $error("read_color: beat with nothing expected, actual %06h", out_tdata);
          err_cnt++;
        end else begin
          want = pend_colors.pop_front();
          if (out_tdata !== want) begin
            $error("read_color mismatch: expected %06h, actual %06h", want, out_tdata);
            err_cnt++;
          end
        end
      end
      // long hold-off backs the block up into its input
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_cmd(action_t act, int x, int y, int a, int b, logic [COLOR_W-1:0] col);
    fill_cmd_t c;
    c.act = act;
    c.px = POS_W'(x);
    c.py = POS_W'(y);
    c.ea = EXT_W'(a);
    c.eb = EXT_W'(b);
    c.color = col;
    cmd_q.push_back(c);
  endtask

  // everything sent has been answered and the block has settled
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_tvalid || pend_colors.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random commands around a w x h frame; huge extents only where the frame is tiny
  task automatic queue_random(int n, int w, int h);
    int sel, x, y, a, b;
    action_t act;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      act = (sel < 20) ? ACT_DISC : (sel < 40) ? ACT_RECT : (sel < 60) ? ACT_BLIT : ACT_READ;
      x = int'($urandom_range(w + 16)) - 8;
      y = int'($urandom_range(h + 16)) - 8;
      a = $urandom_range(12);
      b = $urandom_range(12);
      if ($urandom_range(99) < 8) x = $urandom_range(65535);
      if ($urandom_range(99) < 8) y = $urandom_range(65535);
      if (w * h <= 1024) begin
        if ($urandom_range(99) < 10) a = $urandom_range(32767);
        if ($urandom_range(99) < 10) b = $urandom_range(32767);
      end
      queue_cmd(act, x, y, a, b, COLOR_W'($urandom()));
    end
  endtask

  initial begin : seq
    int w_eff, h_eff;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed commands on the reset frame size
    queue_cmd(ACT_READ, 0, 0, 0, 0, 24'h0);
    queue_cmd(ACT_READ, 255, 255, 0, 0, 24'h0);
    queue_cmd(ACT_DISC, 10, 10, 0, 0, 24'h000000);           // zero radius
    queue_cmd(ACT_READ, 10, 10, 0, 0, 24'h0);
    queue_cmd(ACT_DISC, 0, 0, 5, 0, 24'h123456);             // clipped at corner
    queue_cmd(ACT_READ, 0, 5, 0, 0, 24'h0);
    queue_cmd(ACT_RECT, 250, 250, 20, 20, 24'hABCDEF);       // clipped at far edges
    queue_cmd(ACT_READ, 255, 255, 0, 0, 24'h0);
    queue_cmd(ACT_RECT, 5, 5, 0, 9, 24'h000000);             // zero width
    queue_cmd(ACT_RECT, 5, 5, 9, 0, 24'h000000);             // zero height
    queue_cmd(ACT_READ, 5, 5, 0, 0, 24'h0);
    queue_cmd(ACT_BLIT, -3, -4, 3, 4, 24'h00FF00);           // lands on origin
    queue_cmd(ACT_READ, 0, 0, 0, 0, 24'h0);
    queue_cmd(ACT_BLIT, 200, 0, 100, 0, 24'hFFFFFF);         // off the frame
    queue_cmd(ACT_READ, -1, 0, 0, 0, 24'h0);
    queue_cmd(ACT_READ, 256, 0, 0, 0, 24'h0);
    queue_cmd(ACT_READ, 32767, -32768, 32767, 32767, 24'hFFFFFF);
    queue_cmd(ACT_RECT, -32768, -32768, 32767, 32767, 24'hFFFFFF);
    queue_cmd(ACT_DISC, -32768, 32767, 32767, 32767, 24'h000000);
    queue_cmd(ACT_RECT, 0, 0, 32767, 32767, 24'h5A5A5A);     // whole frame
    queue_cmd(ACT_READ, 128, 77, 0, 0, 24'h0);
    queue_cmd(ACT_DISC, 128, 128, 3, 0, 24'hFFFFFF);
    queue_cmd(ACT_READ, 128, 131, 0, 0, 24'h0);              // on the rim
    queue_cmd(ACT_READ, 131, 131, 0, 0, 24'h0);              // just outside

    // random phases, each on its own frame size
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_reg(CFG_IDX_WIDTH, CFG_DATA_W'(phase_w[p]));
      write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'(phase_h[p]));
      if (p == 2) begin
        // writes to unused indexes must not disturb the frame size
        write_reg(CFG_IDX_RSVD2, 9'h1FF);
        write_reg(CFG_IDX_RSVD3, 9'h000);
      end
      @(negedge clk);
      if (p < 3) begin
        tx_idle_pct = 12;
        rx_idle_pct = 60;
      end else if (p < 6) begin
        tx_idle_pct = 60;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      w_eff = (phase_w[p] > MAX_WIDTH) ? MAX_WIDTH : phase_w[p];
      h_eff = (phase_h[p] > MAX_HEIGHT) ? MAX_HEIGHT : phase_h[p];
      queue_random(phase_n[p], w_eff, h_eff);
      if (p == 4) hold_req = 1'b1;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/fbf_pkg.sv
sv/fbf_ram.sv
sv/framebuffer_fill_engine.sv
sv/fbf_checker.sv
sim/tb_framebuffer_fill_engine.sv
